FILE: src/fcp_pkg.sv
// Shared types and constants of the framed command parser.
// Used by every module of the block; depends on nothing.
package fcp_pkg;

   // Default sizes handed to the top level parameters.
   localparam int DEFAULT_BUFFER_DEPTH  = 64;
   localparam int DEFAULT_TABLE_ENTRIES = 4;
   localparam int DEFAULT_COMMAND_CHARS = 8;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Widths of the register port.
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 64;

   // Register reset values.
   localparam logic [7:0] RESET_START_CHAR = 8'd60;
   localparam logic [7:0] RESET_END_CHAR   = 8'd62;
   localparam logic [7:0] RESET_DELIM_CHAR = 8'd44;

   // Register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_CHAR = 4'd0,
      CSR_END_CHAR   = 4'd1,
      CSR_DELIM_CHAR = 4'd2,
      CSR_CMD_COUNT  = 4'd3,
      CSR_CMD_WORD_0 = 4'd4,
      CSR_CMD_WORD_1 = 4'd5,
      CSR_CMD_WORD_2 = 4'd6,
      CSR_CMD_WORD_3 = 4'd7
   } csr_index_type;

   // Operations passed from the front to the back.
   typedef enum logic [1:0] {
      OP_START,
      OP_STORE,
      OP_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } push_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MATCH,
      ST_STREAM,
      ST_EMPTY
   } back_state_type;

   // Settings that the back end needs at dispatch.
   typedef struct packed {
      logic [7:0] delim;
      logic [2:0] count;
   } back_cfg_type;

   // One result item.
   typedef struct packed {
      logic [1:0] matched_index;
      logic [6:0] part_total;
      logic [6:0] part_index;
      logic [7:0] frame_byte;
      logic       byte_valid;
      logic       is_delimiter;
      logic       overflowed;
      logic       last;
   } result_type;

   // Back end status for checking.
   typedef struct packed {
      logic [6:0] length;
      logic       busy;
   } back_status_type;

endpackage

FILE: src/fcp_front.sv
// Front end: accepts received bytes, tracks the open frame and classifies each item.
// Depends on fcp_pkg for the operation codes and the queue entry type.
module fcp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic [7:0]         start_char,
   input  logic [7:0]         end_char,
   input  logic               queue_full,
   output fcp_pkg::push_type  push
);

   logic in_frame_ff;
   logic in_frame_in;
   logic accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Start wins over end; other bytes are kept only inside a frame and when nonzero.
   always_comb begin
      in_frame_in      = in_frame_ff;
      push.valid       = 1'b0;
      push.entry.op    = fcp_pkg::OP_STORE;
      push.entry.data  = req_rx_byte;
      if (accept) begin
         if (req_rx_byte == start_char) begin
            push.valid    = 1'b1;
            push.entry.op = fcp_pkg::OP_START;
            in_frame_in   = 1'b1;
         end else if (req_rx_byte == end_char) begin
            push.valid    = 1'b1;
            push.entry.op = fcp_pkg::OP_END;
            in_frame_in   = 1'b0;
         end else if (in_frame_ff && (req_rx_byte != 8'd0)) begin
            push.valid    = 1'b1;
         end
      end
   end

   // Frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

FILE: src/fcp_queue.sv
// Short queue of classified items between the front and the back end.
// Depends on fcp_pkg for the entry type and the queue depth.
module fcp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  fcp_pkg::push_type         push,
   output logic                      full,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output fcp_pkg::queue_entry_type  pop_entry
);

   localparam int DEPTH = fcp_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   fcp_pkg::queue_entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

FILE: src/fcp_back.sv
// Back end: frame memory, command match scan and result streaming.
// Depends on fcp_pkg for the state, operation, configuration and result types.
module fcp_back #(
   parameter int BUFFER_DEPTH  = fcp_pkg::DEFAULT_BUFFER_DEPTH,
   parameter int TABLE_ENTRIES = fcp_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int COMMAND_CHARS = fcp_pkg::DEFAULT_COMMAND_CHARS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  fcp_pkg::queue_entry_type        pop_entry,
   input  fcp_pkg::back_cfg_type           cfg,
   input  logic [8*COMMAND_CHARS-1:0]      command_word [TABLE_ENTRIES],
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output fcp_pkg::result_type             rsp,
   output fcp_pkg::back_status_type        status
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int LW = $clog2(BUFFER_DEPTH + 2);
   localparam int CW = (COMMAND_CHARS > 1) ? $clog2(COMMAND_CHARS) : 1;

   fcp_pkg::back_state_type state_ff, state_in;

   logic [7:0]              frame_mem [BUFFER_DEPTH];
   logic [7:0]              rd_data_ff;

   logic [LW-1:0]           len_ff;
   logic                    ovf_ff;
   logic [LW-1:0]           issue_ff;
   logic                    pend_ff;
   logic [LW-1:0]           head_ff;
   logic                    head_done_ff;
   logic [TABLE_ENTRIES-1:0] eq_ff;
   logic [LW-1:0]           total_ff;
   logic [1:0]              hit_ff;
   logic [LW-1:0]           part_ff;
   logic [LW-1:0]           sent_ff;
   logic                    data_ok_ff;
   logic                    rsp_valid_ff;
   fcp_pkg::result_type     rsp_ff;

   // Control decoded from the state.
   logic op_start, op_store, op_end;
   logic mem_we, mem_re;
   logic scan_done;
   logic out_free;
   logic consume;
   logic last_byte;
   logic load_empty;
   logic clear_frame;

   // Match evaluation.
   logic [LW-1:0]           word_len [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] eq_next;
   logic [2:0]              used;
   logic                    hit_found;
   logic [1:0]              hit_index;
   logic                    rd_is_delim;

   assign rd_is_delim = (rd_data_ff == cfg.delim);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign scan_done   = (issue_ff == len_ff) && !pend_ff;
   assign last_byte   = ((sent_ff + 1'b1) == len_ff);

   // Length of each command text: up to its first zero byte.
   always_comb begin
      for (int t = 0; t < TABLE_ENTRIES; t++) begin
         word_len[t] = LW'(COMMAND_CHARS);
         for (int k = COMMAND_CHARS - 1; k >= 0; k--) begin
            if (command_word[t][8*k +: 8] == 8'd0) begin
               word_len[t] = LW'(k);
            end
         end
      end
   end

   // First entry in table order whose text equals the first part.
   always_comb begin
      used      = (cfg.count > 3'(TABLE_ENTRIES)) ? 3'(TABLE_ENTRIES) : cfg.count;
      hit_found = 1'b0;
      hit_index = '0;
      for (int t = TABLE_ENTRIES - 1; t >= 0; t--) begin
         if ((3'(t) < used) && eq_ff[t] && (word_len[t] == head_ff)) begin
            hit_found = 1'b1;
            hit_index = 2'(t);
         end
      end
   end

   // Running comparison of the first part against every entry, one byte a cycle.
   always_comb begin
      for (int t = 0; t < TABLE_ENTRIES; t++) begin
         eq_next[t] = eq_ff[t] && (head_ff < LW'(COMMAND_CHARS)) &&
                      (command_word[t][8*head_ff[CW-1:0] +: 8] == rd_data_ff);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fcp_pkg::ST_IDLE: begin
            if (pop_valid && (pop_entry.op == fcp_pkg::OP_END)) begin
               state_in = fcp_pkg::ST_SCAN;
            end
         end
         fcp_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = fcp_pkg::ST_MATCH;
            end
         end
         fcp_pkg::ST_MATCH: begin
            if (!hit_found) begin
               state_in = fcp_pkg::ST_IDLE;
            end else if (len_ff == '0) begin
               state_in = fcp_pkg::ST_EMPTY;
            end else begin
               state_in = fcp_pkg::ST_STREAM;
            end
         end
         fcp_pkg::ST_STREAM: begin
            if (consume && last_byte) begin
               state_in = fcp_pkg::ST_IDLE;
            end
         end
         fcp_pkg::ST_EMPTY: begin
            if (out_free) begin
               state_in = fcp_pkg::ST_IDLE;
            end
         end
         default: state_in = fcp_pkg::ST_IDLE;
      endcase
   end

   // Control outputs of each state.
   always_comb begin
      pop_ready   = 1'b0;
      op_start    = 1'b0;
      op_store    = 1'b0;
      op_end      = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      consume     = 1'b0;
      load_empty  = 1'b0;
      clear_frame = 1'b0;
      unique case (state_ff)
         fcp_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               op_start = (pop_entry.op == fcp_pkg::OP_START);
               op_store = (pop_entry.op == fcp_pkg::OP_STORE);
               op_end   = (pop_entry.op == fcp_pkg::OP_END);
            end
            mem_we = op_store && (len_ff < LW'(BUFFER_DEPTH));
         end
         fcp_pkg::ST_SCAN: begin
            mem_re = (issue_ff < len_ff);
         end
         fcp_pkg::ST_MATCH: begin
            clear_frame = !hit_found;
         end
         fcp_pkg::ST_STREAM: begin
            consume     = data_ok_ff && out_free;
            mem_re      = (issue_ff < len_ff) && (!data_ok_ff || consume);
            clear_frame = consume && last_byte;
         end
         fcp_pkg::ST_EMPTY: begin
            load_empty  = out_free;
            clear_frame = out_free;
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   // Frame memory: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[len_ff[AW-1:0]] <= pop_entry.data;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[issue_ff[AW-1:0]];
      end
   end

   // Sequencer and frame bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcp_pkg::ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         data_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Frame length and overflow flag.
         if (op_start || clear_frame) begin
            len_ff <= '0;
            ovf_ff <= 1'b0;
         end else if (mem_we) begin
            len_ff <= len_ff + 1'b1;
         end else if (op_store) begin
            ovf_ff <= 1'b1;
         end

         // Read issue counter, restarted for the scan and for the stream.
         if (op_end || ((state_ff == fcp_pkg::ST_MATCH))) begin
            issue_ff <= '0;
         end else if (mem_re) begin
            issue_ff <= issue_ff + 1'b1;
         end

         pend_ff <= mem_re && (state_ff == fcp_pkg::ST_SCAN);

         // Prefetched byte held until the output register takes it.
         if (state_ff == fcp_pkg::ST_STREAM) begin
            data_ok_ff <= mem_re || (data_ok_ff && !consume);
         end else begin
            data_ok_ff <= 1'b0;
         end

         // Output register.
         if (consume || load_empty) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Scan accumulators, stream counters and result payload.
   always_ff @(posedge clock) begin
      if (op_end) begin
         head_ff      <= '0;
         head_done_ff <= 1'b0;
         eq_ff        <= '1;
         total_ff     <= LW'(1);
      end else if (pend_ff) begin
         total_ff <= total_ff + LW'(rd_is_delim);
         if (!head_done_ff) begin
            if (rd_is_delim) begin
               head_done_ff <= 1'b1;
            end else begin
               eq_ff   <= eq_next;
               head_ff <= head_ff + 1'b1;
            end
         end
      end

      if (state_ff == fcp_pkg::ST_MATCH) begin
         hit_ff  <= hit_index;
         part_ff <= '0;
         sent_ff <= '0;
      end else if (consume) begin
         part_ff <= part_ff + LW'(rd_is_delim);
         sent_ff <= sent_ff + 1'b1;
      end

      if (consume) begin
         rsp_ff.matched_index <= hit_ff;
         rsp_ff.part_total    <= 7'(total_ff);
         rsp_ff.part_index    <= 7'(part_ff);
         rsp_ff.frame_byte    <= rd_data_ff;
         rsp_ff.byte_valid    <= 1'b1;
         rsp_ff.is_delimiter  <= rd_is_delim;
         rsp_ff.overflowed    <= ovf_ff;
         rsp_ff.last          <= last_byte;
      end else if (load_empty) begin
         rsp_ff.matched_index <= hit_ff;
         rsp_ff.part_total    <= 7'd1;
         rsp_ff.part_index    <= 7'd0;
         rsp_ff.frame_byte    <= 8'd0;
         rsp_ff.byte_valid    <= 1'b0;
         rsp_ff.is_delimiter  <= 1'b0;
         rsp_ff.overflowed    <= ovf_ff;
         rsp_ff.last          <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp           = rsp_ff;
   assign status.length = 7'(len_ff);
   assign status.busy   = (state_ff != fcp_pkg::ST_IDLE);

endmodule

FILE: src/framed_command_parser.sv
// Top level of the framed command parser: register file, front end, queue and back end.
// Depends on fcp_pkg, fcp_front, fcp_queue and fcp_back.
//
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_rx_byte
// rsp       out        rsp_valid/rsp_ready  rsp_matched_index .. rsp_last
// csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// The front end takes a byte every cycle while the two-entry queue has room.
// The back end takes start and stored bytes from the queue while idle; a matching dispatch
// of a frame keeps it busy, as the single-port frame memory is read once for the command
// match scan and once more for the result stream.
// Reset is synchronous and sets the registers to their reset values; it clears the open frame and the queue.
// A stalled result holds in the output register; the back end waits while it has more of
// the frame to send, and the front end keeps accepting bytes until the queue fills.
module framed_command_parser #(
   parameter int BUFFER_DEPTH  = fcp_pkg::DEFAULT_BUFFER_DEPTH,
   parameter int TABLE_ENTRIES = fcp_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int COMMAND_CHARS = fcp_pkg::DEFAULT_COMMAND_CHARS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_matched_index,
   output logic [6:0]                          rsp_part_total,
   output logic [6:0]                          rsp_part_index,
   output logic [7:0]                          rsp_frame_byte,
   output logic                                rsp_byte_valid,
   output logic                                rsp_is_delimiter,
   output logic                                rsp_overflowed,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fcp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fcp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int WW = 8 * COMMAND_CHARS;

   logic [7:0]    start_ff, start_in;
   logic [7:0]    end_ff, end_in;
   logic [7:0]    delim_ff, delim_in;
   logic [2:0]    count_ff, count_in;
   logic [WW-1:0] word_ff [TABLE_ENTRIES];
   logic [WW-1:0] word_in [TABLE_ENTRIES];
   logic          csr_write;

   fcp_pkg::push_type         push;
   fcp_pkg::queue_entry_type  pop_entry;
   fcp_pkg::back_cfg_type     back_cfg;
   fcp_pkg::result_type       rsp;
   fcp_pkg::back_status_type  back_status;
   logic                      queue_full;
   logic                      pop_valid;
   logic                      pop_ready;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register write decode; indexes beyond the list are ignored.
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      delim_in = delim_ff;
      count_in = count_ff;
      for (int t = 0; t < TABLE_ENTRIES; t++) begin
         word_in[t] = word_ff[t];
      end
      if (csr_write) begin
         unique case (csr_index)
            fcp_pkg::CSR_START_CHAR: start_in = csr_wdata[7:0];
            fcp_pkg::CSR_END_CHAR:   end_in   = csr_wdata[7:0];
            fcp_pkg::CSR_DELIM_CHAR: delim_in = csr_wdata[7:0];
            fcp_pkg::CSR_CMD_COUNT:  count_in = csr_wdata[2:0];
            default: begin
               for (int t = 0; t < TABLE_ENTRIES; t++) begin
                  if (int'(csr_index) == (int'(fcp_pkg::CSR_CMD_WORD_0) + t)) begin
                     word_in[t] = csr_wdata[WW-1:0];
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= fcp_pkg::RESET_START_CHAR;
         end_ff   <= fcp_pkg::RESET_END_CHAR;
         delim_ff <= fcp_pkg::RESET_DELIM_CHAR;
         count_ff <= '0;
         for (int t = 0; t < TABLE_ENTRIES; t++) begin
            word_ff[t] <= '0;
         end
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
         delim_ff <= delim_in;
         count_ff <= count_in;
         for (int t = 0; t < TABLE_ENTRIES; t++) begin
            word_ff[t] <= word_in[t];
         end
      end
   end

   assign back_cfg.delim = delim_ff;
   assign back_cfg.count = count_ff;

   // Classification of incoming bytes.
   fcp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .start_char  (start_ff),
      .end_char    (end_ff),
      .queue_full  (queue_full),
      .push        (push)
   );

   // Queue between the two halves.
   fcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry)
   );

   // Frame storage, matching and result stream.
   fcp_back #(
      .BUFFER_DEPTH  (BUFFER_DEPTH),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COMMAND_CHARS (COMMAND_CHARS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_entry    (pop_entry),
      .cfg          (back_cfg),
      .command_word (word_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp          (rsp),
      .status       (back_status)
   );

   assign rsp_matched_index = rsp.matched_index;
   assign rsp_part_total    = rsp.part_total;
   assign rsp_part_index    = rsp.part_index;
   assign rsp_frame_byte    = rsp.frame_byte;
   assign rsp_byte_valid    = rsp.byte_valid;
   assign rsp_is_delimiter  = rsp.is_delimiter;
   assign rsp_overflowed    = rsp.overflowed;
   assign rsp_last          = rsp.last;

   // A start byte that is accepted always reaches the queue.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_rx_byte == start_ff)) |=> pop_valid)
      else $error("start item did not reach the queue");

   // The frame never grows beyond the buffer.
   assert property (@(posedge clock) disable iff (reset)
      back_status.length <= 7'(BUFFER_DEPTH))
      else $error("frame length beyond buffer depth");

   // A busy back end takes nothing from the queue.
   assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> !pop_ready)
      else $error("queue popped while the back end was busy");

   // An empty frame result is always the only and last one of its run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_last && (rsp_part_total == 7'd1)))
      else $error("empty frame result without last flag");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the framed command parser: directed table, then random frames.
// Depends on fcp_pkg and framed_command_parser; every result item is checked against
// a local byte-level model of the parser, or a hand-written item for typed directed rows.
`timescale 1ns / 100ps

module testbench;

   localparam int BUFFER_DEPTH  = fcp_pkg::DEFAULT_BUFFER_DEPTH;
   localparam int TABLE_ENTRIES = fcp_pkg::DEFAULT_TABLE_ENTRIES;
   localparam int COMMAND_CHARS = fcp_pkg::DEFAULT_COMMAND_CHARS;

   // Register index outside the list; the block must ignore writes to it.
   localparam logic [fcp_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 4'd15;

   // Cycles allowed for a frame scan with no result, plus the queue contents.
   localparam int SETTLE_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 110;
   localparam int PHASE_ITEMS    = 6;
   localparam int IDLE_PERCENT   = 7;
   localparam int DIRECTED_ROWS  = 29;

   localparam fcp_pkg::result_type NO_RESULT   = '0;
   // Empty buffer matched by the empty command text in table position 1.
   localparam fcp_pkg::result_type EMPTY_MATCH =
      '{2'd1, 7'd1, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
   // Single byte 'A' matched by table position 3.
   localparam fcp_pkg::result_type SINGLE_A    =
      '{2'd3, 7'd1, 7'd0, 8'h41, 1'b1, 1'b0, 1'b0, 1'b1};

   typedef enum bit {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                        kind;
      logic [fcp_pkg::CSR_INDEX_WIDTH-1:0] index;
      logic [63:0]                         value;
      bit                                  typed;
      int                                  typed_count;
      fcp_pkg::result_type                 typed_result;
   } stimulus_row_type;

   // Clock and ports of the block.
   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [7:0] req_rx_byte;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_matched_index;
   logic [6:0] rsp_part_total;
   logic [6:0] rsp_part_index;
   logic [7:0] rsp_frame_byte;
   logic rsp_byte_valid;
   logic rsp_is_delimiter;
   logic rsp_overflowed;
   logic rsp_last;
   logic csr_valid;
   logic csr_ready;
   logic [fcp_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [fcp_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;

   // Model state and register copies.
   logic frame_open;
   logic [7:0] frame_bytes [BUFFER_DEPTH];
   int frame_len;
   logic frame_over;
   logic [7:0] cfg_start;
   logic [7:0] cfg_end;
   logic [7:0] cfg_delim;
   logic [2:0] cfg_count;
   logic [63:0] cfg_word [TABLE_ENTRIES];

   fcp_pkg::result_type expected_results [$];
   fcp_pkg::result_type new_results [$];

   // Hand-written expectation for the byte currently offered.
   bit row_typed = 1'b0;
   int row_typed_count = 0;
   fcp_pkg::result_type row_typed_result = '0;

   int failures = 0;
   int random_items = 0;
   int idle_cycles = 0;
   bit steady = 1'b0;

   // Directed rows: reset state, table extremes, empty frame, zero byte, full-width command.
   stimulus_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_BYTE, '0, 64'h3E, 1'b1, 0, NO_RESULT},
      '{ROW_CSR, fcp_pkg::CSR_CMD_WORD_0, 64'h4241, 1'b0, 0, NO_RESULT},
      '{ROW_CSR, fcp_pkg::CSR_CMD_WORD_1, 64'h0, 1'b0, 0, NO_RESULT},
      '{ROW_CSR, fcp_pkg::CSR_CMD_WORD_2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, NO_RESULT},
      '{ROW_CSR, fcp_pkg::CSR_CMD_WORD_3, 64'h7A00_0000_0000_0041, 1'b0, 0, NO_RESULT},
      '{ROW_CSR, fcp_pkg::CSR_CMD_COUNT, 64'h7, 1'b0, 0, NO_RESULT},
      '{ROW_CSR, CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h3E, 1'b1, 1, EMPTY_MATCH},
      '{ROW_BYTE, '0, 64'h3C, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h41, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h42, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h2C, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h78, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h3E, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h3C, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h41, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h00, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h3E, 1'b1, 1, SINGLE_A},
      '{ROW_BYTE, '0, 64'h51, 1'b1, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h3C, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'hFF, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'hFF, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'hFF, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'hFF, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'hFF, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'hFF, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'hFF, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'hFF, 1'b0, 0, NO_RESULT},
      '{ROW_BYTE, '0, 64'h3E, 1'b0, 0, NO_RESULT}
   };

   framed_command_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched_index (rsp_matched_index),
      .rsp_part_total    (rsp_part_total),
      .rsp_part_index    (rsp_part_index),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_is_delimiter  (rsp_is_delimiter),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Table position of the first command word equal to the first part, or -1.
   function automatic int find_command();
      int head;
      int used;
      int wlen;
      bit same;
      head = 0;
      while (head < frame_len && frame_bytes[head] != cfg_delim) head++;
      used = (cfg_count > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cfg_count);
      for (int t = 0; t < used; t++) begin
         wlen = 0;
         while (wlen < COMMAND_CHARS && cfg_word[t][8*wlen +: 8] != 8'h00) wlen++;
         if (wlen != head) continue;
         same = 1'b1;
         for (int k = 0; k < wlen; k++) begin
            if (cfg_word[t][8*k +: 8] != frame_bytes[k]) same = 1'b0;
         end
         if (same) return t;
      end
      return -1;
   endfunction

   // Advances the model by one byte and leaves the result items it causes in new_results.
   function automatic void predict_byte(input logic [7:0] c);
      int hit;
      int total;
      int part;
      fcp_pkg::result_type r;
      new_results.delete();
      if (c == cfg_start) begin
         frame_open = 1'b1;
         frame_len = 0;
         frame_over = 1'b0;
      end else if (c == cfg_end) begin
         hit = find_command();
         if (hit >= 0) begin
            total = 1;
            for (int i = 0; i < frame_len; i++) begin
               if (frame_bytes[i] == cfg_delim) total++;
            end
            if (frame_len == 0) begin
               r = '0;
               r.matched_index = 2'(hit);
               r.part_total = 7'd1;
               r.overflowed = frame_over;
               r.last = 1'b1;
               new_results.push_back(r);
            end else begin
               part = 0;
               for (int i = 0; i < frame_len; i++) begin
                  r.matched_index = 2'(hit);
                  r.part_total = 7'(total);
                  r.part_index = 7'(part);
                  r.frame_byte = frame_bytes[i];
                  r.byte_valid = 1'b1;
                  r.is_delimiter = (frame_bytes[i] == cfg_delim);
                  r.overflowed = frame_over;
                  r.last = (i == frame_len - 1);
                  new_results.push_back(r);
                  if (r.is_delimiter) part++;
               end
            end
         end
         frame_len = 0;
         frame_over = 1'b0;
         frame_open = 1'b0;
      end else if (frame_open && c != 8'h00) begin
         if (frame_len < BUFFER_DEPTH) begin
            frame_bytes[frame_len] = c;
            frame_len++;
         end else begin
            frame_over = 1'b1;
         end
      end
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endfunction

   // A nonzero byte that is none of the framing characters.
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255, 1));
      while (b == cfg_start || b == cfg_end || b == cfg_delim);
      return b;
   endfunction

   // Compare accepted result items, then run the model on accepted input items.
   always @(posedge clock) begin : monitor
      fcp_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result item arrived with no expected item waiting");
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("matched_index", 8'(want.matched_index), 8'(rsp_matched_index));
               check_field("part_total", 8'(want.part_total), 8'(rsp_part_total));
               check_field("part_index", 8'(want.part_index), 8'(rsp_part_index));
               check_field("frame_byte", want.frame_byte, rsp_frame_byte);
               check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_byte_valid));
               check_field("is_delimiter", 8'(want.is_delimiter), 8'(rsp_is_delimiter));
               check_field("overflowed", 8'(want.overflowed), 8'(rsp_overflowed));
               check_field("last", 8'(want.last), 8'(rsp_last));
            end
         end
         if (req_valid && req_ready) begin
            predict_byte(req_rx_byte);
            if (!row_typed) begin
               foreach (new_results[i]) expected_results.push_back(new_results[i]);
            end else if (row_typed_count != 0) begin
               expected_results.push_back(row_typed_result);
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Ends the run if no channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("framed_command_parser test failed");
            $finish;
         end
      end
   end

   // Offers one byte; valid is left high so that the next item can follow at once.
   task automatic send_byte(input logic [7:0] value, input bit typed, input int typed_count,
                            input fcp_pkg::result_type typed_result);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      row_typed <= typed;
      row_typed_count <= typed_count;
      row_typed_result <= typed_result;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
      random_items++;
   endtask

   // Writes one register and mirrors it in the model once accepted.
   task automatic write_register(input logic [fcp_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [63:0] value);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         fcp_pkg::CSR_START_CHAR: cfg_start = value[7:0];
         fcp_pkg::CSR_END_CHAR:   cfg_end = value[7:0];
         fcp_pkg::CSR_DELIM_CHAR: cfg_delim = value[7:0];
         fcp_pkg::CSR_CMD_COUNT:  cfg_count = value[2:0];
         fcp_pkg::CSR_CMD_WORD_0: cfg_word[0] = value;
         fcp_pkg::CSR_CMD_WORD_1: cfg_word[1] = value;
         fcp_pkg::CSR_CMD_WORD_2: cfg_word[2] = value;
         fcp_pkg::CSR_CMD_WORD_3: cfg_word[3] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Stops offering bytes and waits until the block has drained.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Framing characters and command table for one phase of the random part.
   task automatic program_phase(input int phase);
      logic [7:0] s;
      logic [7:0] e;
      logic [7:0] d;
      logic [63:0] w [TABLE_ENTRIES];
      int len;
      case (phase % 6)
         0: begin
            s = fcp_pkg::RESET_START_CHAR;
            e = fcp_pkg::RESET_END_CHAR;
            d = fcp_pkg::RESET_DELIM_CHAR;
         end
         1: begin
            s = 8'h00;
            e = 8'hFF;
            d = 8'h01;
         end
         2: begin
            s = 8'hFF;
            e = 8'h00;
            d = 8'hFE;
         end
         3: begin
            // Start and end share one value.
            s = 8'($urandom_range(255));
            e = s;
            d = 8'($urandom_range(255));
         end
         4: begin
            s = 8'($urandom_range(255));
            e = 8'($urandom_range(255));
            d = s;
         end
         default: begin
            s = 8'($urandom_range(255));
            e = 8'($urandom_range(255));
            d = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
         end
      endcase
      write_register(fcp_pkg::CSR_START_CHAR, 64'(s));
      write_register(fcp_pkg::CSR_END_CHAR, 64'(e));
      write_register(fcp_pkg::CSR_DELIM_CHAR, 64'(d));
      for (int t = 0; t < TABLE_ENTRIES; t++) begin
         len = $urandom_range(COMMAND_CHARS);
         w[t] = '0;
         for (int k = 0; k < len; k++) w[t][8*k +: 8] = text_byte();
         // Junk above the terminator must not count.
         if (len < COMMAND_CHARS - 1 && $urandom_range(1)) w[t][63:56] = 8'($urandom_range(255));
      end
      // A repeated word checks that table order decides.
      if ($urandom_range(3) == 0) w[3] = w[1];
      for (int t = 0; t < TABLE_ENTRIES; t++) begin
         write_register(fcp_pkg::csr_index_type'(int'(fcp_pkg::CSR_CMD_WORD_0) + t), w[t]);
      end
      write_register(fcp_pkg::CSR_CMD_COUNT,
                     (phase % 6 == 4) ? 64'd0 : 64'($urandom_range(4, 1)));
   endtask

   // One frame, mostly well formed; sometimes noise or a frame left open.
   task automatic send_frame(input bit force_long);
      int n;
      int k;
      logic [63:0] w;
      logic [7:0] b;
      if (!force_long && $urandom_range(99) < 15) begin
         n = $urandom_range(6, 1);
         repeat (n) begin
            case ($urandom_range(5))
               0: b = cfg_start;
               1: b = cfg_end;
               2: b = cfg_delim;
               3: b = 8'h00;
               default: b = 8'($urandom_range(255));
            endcase
            send_byte(b, 1'b0, 0, NO_RESULT);
         end
         return;
      end
      send_byte(cfg_start, 1'b0, 0, NO_RESULT);
      // First part: usually a command text, otherwise random text of zero to nine bytes.
      if (force_long || $urandom_range(99) < 80) begin
         w = cfg_word[force_long ? 0 : $urandom_range(TABLE_ENTRIES - 1)];
         for (k = 0; k < COMMAND_CHARS && w[8*k +: 8] != 8'h00; k++) begin
            send_byte(w[8*k +: 8], 1'b0, 0, NO_RESULT);
         end
      end else begin
         n = $urandom_range(COMMAND_CHARS + 1);
         repeat (n) send_byte(text_byte(), 1'b0, 0, NO_RESULT);
      end
      if (force_long || $urandom_range(23) == 0) begin
         // Long tail that fills the buffer and often overflows it.
         n = force_long ? 70 : $urandom_range(72, 62);
         send_byte(cfg_delim, 1'b0, 0, NO_RESULT);
         repeat (n - 1) begin
            send_byte(($urandom_range(7) == 0) ? cfg_delim : text_byte(), 1'b0, 0, NO_RESULT);
         end
      end else begin
         n = $urandom_range(3);
         repeat (n) begin
            send_byte(cfg_delim, 1'b0, 0, NO_RESULT);
            k = $urandom_range(5);
            repeat (k) begin
               send_byte(($urandom_range(19) == 0) ? 8'h00 : text_byte(), 1'b0, 0, NO_RESULT);
            end
         end
      end
      if ($urandom_range(19) != 0) send_byte(cfg_end, 1'b0, 0, NO_RESULT);
   endtask

   // Reset, directed table, random phases, verdict.
   initial begin : stimulus
      int phase;
      int phase_start;
      bit bytes_pending;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;
      frame_open = 1'b0;
      frame_len = 0;
      frame_over = 1'b0;
      cfg_start = fcp_pkg::RESET_START_CHAR;
      cfg_end = fcp_pkg::RESET_END_CHAR;
      cfg_delim = fcp_pkg::RESET_DELIM_CHAR;
      cfg_count = '0;
      foreach (cfg_word[t]) cfg_word[t] = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed table; registers are only written once the block has drained.
      bytes_pending = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            if (bytes_pending) wait_until_drained();
            bytes_pending = 1'b0;
            write_register(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
                      directed_rows[i].typed_count, directed_rows[i].typed_result);
            bytes_pending = 1'b1;
         end
      end

      // Random phases, each with its own framing characters and command table.
      random_items = 0;
      for (phase = 0; phase < 6 || random_items < RANDOM_ITEMS; phase++) begin
         wait_until_drained();
         program_phase(phase);
         steady = (phase == 2);
         phase_start = random_items;
         send_frame(phase == 1);
         while (random_items - phase_start < PHASE_ITEMS) send_frame(1'b0);
      end
      steady = 1'b0;
      wait_until_drained();

      if (failures == 0) begin
         $display("framed_command_parser test passed");
      end else begin
         $display("framed_command_parser test failed");
      end
      $finish;
   end

endmodule

FILE: framed_command_parser.f
src/fcp_pkg.sv
src/fcp_front.sv
src/fcp_queue.sv
src/fcp_back.sv
src/framed_command_parser.sv
tb/testbench.sv
